FILE: rtl/core/bbc_pkg.sv
package bbc_pkg;

  localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
  localparam logic [7:0] CH_OPEN_ANGLE   = 8'h3C;
  localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
  localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;

  localparam logic [1:0] KIND_PAREN  = 2'd0;
  localparam logic [1:0] KIND_SQUARE = 2'd1;
  localparam logic [1:0] KIND_CURLY  = 2'd2;
  localparam logic [1:0] KIND_ANGLE  = 2'd3;

  localparam logic [1:0] VERDICT_BALANCED = 2'd0;
  localparam logic [1:0] VERDICT_MISMATCH = 2'd1;
  localparam logic [1:0] VERDICT_UNCLOSED = 2'd2;
  localparam logic [1:0] VERDICT_OVERFLOW = 2'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  typedef struct packed {
    logic       open;
    logic       close;
    logic [1:0] kind;
    logic       last;
  } op_t;

endpackage

FILE: rtl/core/bbc_front.sv
module bbc_front (
  input  logic [7:0]     ch,
  input  logic           last,
  output bbc_pkg::op_t   op
);

  always_comb begin
    op.open  = 1'b0;
    op.close = 1'b0;
    op.kind  = bbc_pkg::KIND_PAREN;
    op.last  = last;
    unique case (ch)
      bbc_pkg::CH_OPEN_PAREN: begin
        op.open = 1'b1;
        op.kind = bbc_pkg::KIND_PAREN;
      end
      bbc_pkg::CH_OPEN_SQUARE: begin
        op.open = 1'b1;
        op.kind = bbc_pkg::KIND_SQUARE;
      end
      bbc_pkg::CH_OPEN_CURLY: begin
        op.open = 1'b1;
        op.kind = bbc_pkg::KIND_CURLY;
      end
      bbc_pkg::CH_OPEN_ANGLE: begin
        op.open = 1'b1;
        op.kind = bbc_pkg::KIND_ANGLE;
      end
      bbc_pkg::CH_CLOSE_PAREN: begin
        op.close = 1'b1;
        op.kind  = bbc_pkg::KIND_PAREN;
      end
      bbc_pkg::CH_CLOSE_SQUARE: begin
        op.close = 1'b1;
        op.kind  = bbc_pkg::KIND_SQUARE;
      end
      bbc_pkg::CH_CLOSE_CURLY: begin
        op.close = 1'b1;
        op.kind  = bbc_pkg::KIND_CURLY;
      end
      bbc_pkg::CH_CLOSE_ANGLE: begin
        op.close = 1'b1;
        op.kind  = bbc_pkg::KIND_ANGLE;
      end
      default: begin
        op.open  = 1'b0;
        op.close = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/core/bbc_queue.sv
module bbc_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  bbc_pkg::op_t wr_op,
  output logic         full,
  input  logic         rd_en,
  output bbc_pkg::op_t rd_op,
  output logic         rd_valid
);

  bbc_pkg::op_t                    slots [bbc_pkg::QUEUE_DEPTH];
  logic [bbc_pkg::QUEUE_AW-1:0]    wr_ptr;
  logic [bbc_pkg::QUEUE_AW-1:0]    rd_ptr;
  logic [bbc_pkg::QUEUE_AW:0]      count;
  logic                            do_wr;
  logic                            do_rd;

  assign full     = (count == (bbc_pkg::QUEUE_AW+1)'(bbc_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;
  assign rd_op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/bbc_back.sv
module bbc_back #(
  parameter int STACK_DEPTH = 128
) (
  input  logic         clk,
  input  logic         rst,
  input  bbc_pkg::op_t op,
  input  logic         op_valid,
  output logic         op_take,
  output logic [1:0]   verdict,
  output logic         empty,
  input  logic         pop
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [1:0]    mem [STACK_DEPTH];
  logic [DW-1:0] depth;
  logic [DW-1:0] depth_next;
  logic [1:0]    err;
  logic [1:0]    err_next;
  logic [1:0]    top;
  logic [1:0]    rd_data;
  logic          use_rd;
  logic [1:0]    cur_top;
  logic          do_push;
  logic          do_pop;
  logic [DW-1:0] wr_idx;
  logic [DW-1:0] rd_idx;
  logic [1:0]    verdict_calc;
  logic          out_valid;
  logic          done;

  assign op_take = op_valid && (!out_valid || pop);
  assign done    = op_take && op.last;
  assign cur_top = use_rd ? rd_data : top;
  assign wr_idx  = depth - DW'(1);
  assign rd_idx  = depth - DW'(2);
  assign empty   = !out_valid;

  always_comb begin
    do_push    = 1'b0;
    do_pop     = 1'b0;
    err_next   = err;
    depth_next = depth;
    if (op_take && err == bbc_pkg::VERDICT_BALANCED) begin
      if (op.open) begin
        if (depth == DW'(STACK_DEPTH)) begin
          err_next = bbc_pkg::VERDICT_OVERFLOW;
        end else begin
          do_push    = 1'b1;
          depth_next = depth + DW'(1);
        end
      end else if (op.close) begin
        if (depth == '0 || cur_top != op.kind) begin
          err_next = bbc_pkg::VERDICT_MISMATCH;
        end else begin
          do_pop     = 1'b1;
          depth_next = depth - DW'(1);
        end
      end
    end
    if (err_next != bbc_pkg::VERDICT_BALANCED) begin
      verdict_calc = err_next;
    end else if (depth_next != '0) begin
      verdict_calc = bbc_pkg::VERDICT_UNCLOSED;
    end else begin
      verdict_calc = bbc_pkg::VERDICT_BALANCED;
    end
  end

  // entries below the top live in memory, the top in a register
  always_ff @(posedge clk) begin
    if (do_push && depth != '0) begin
      mem[wr_idx[AW-1:0]] <= cur_top;
    end
    if (do_pop) begin
      rd_data <= mem[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      top <= op.kind;
    end else if (!do_pop) begin
      top <= cur_top;
    end
    if (done) begin
      verdict <= verdict_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      err       <= bbc_pkg::VERDICT_BALANCED;
      use_rd    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      use_rd <= do_pop;
      if (done) begin
        depth <= '0;
        err   <= bbc_pkg::VERDICT_BALANCED;
      end else begin
        depth <= depth_next;
        err   <= err_next;
      end
      if (done) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    done |=> (depth == '0) && (err == bbc_pkg::VERDICT_BALANCED) && out_valid)
    else $error("state not cleared or no word after last character");

  a_pop_refill: assert property (@(posedge clk) disable iff (rst)
    do_pop |=> use_rd)
    else $error("top not refilled from memory after pop");

endmodule

FILE: rtl/core/bracket_balance_checker.sv
// bracket balance checker
// input side is a queue write port: ch and last are taken on a clock edge
// with push high and full low, one character word per cycle
// result side is a queue read port: while empty is low, verdict holds the
// held result, removed on an edge with pop high
// a verdict word appears only for a character with last set:
//   0 balanced, 1 wrong or unmatched closer, 2 unclosed openers, 3 overflow
// the first error of a string is kept; after the last character the stack
// and error are cleared for the next string
// a last character is classified, written into a 2-word queue, then taken
// by the stack update, which registers its verdict when the back end is free
// throughput: 1 character per cycle while no verdict waits unread; the stack
// top sits in a register and the memory has one write or one read per cycle
// if the receiver stalls, one verdict is held and the queue fills; full rises
// once the back end is blocked behind an unread verdict
// reset (rst, synchronous): stack empty, no error, queues empty; no clearing
// pass is needed
module bracket_balance_checker #(
  parameter int STACK_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] ch,
  input  logic       last,
  input  logic       push,
  output logic       full,
  output logic [1:0] verdict,
  output logic       empty,
  input  logic       pop
);

  bbc_pkg::op_t in_op;
  bbc_pkg::op_t q_op;
  logic         q_valid;
  logic         q_take;

  bbc_front u_front (
    .ch   (ch),
    .last (last),
    .op   (in_op)
  );

  bbc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_op    (in_op),
    .full     (full),
    .rd_en    (q_take),
    .rd_op    (q_op),
    .rd_valid (q_valid)
  );

  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (q_op),
    .op_valid (q_valid),
    .op_take  (q_take),
    .verdict  (verdict),
    .empty    (empty),
    .pop      (pop)
  );

endmodule
